// ===== rtl/baa_pkg.sv =====
// Package for the bus address allocator: action and status codes, the
// controller state type, and the structs passed along the cell chain.
// No dependencies.
package baa_pkg;

  localparam int ADDRESS_COUNT_DEF = 128;
  localparam int HANDLE_BITS_DEF   = 32;

  localparam int ADDR_BITS      = 7;
  localparam int LIMIT_BITS     = 8;
  localparam int HANDLE_IN_BITS = 32;
  localparam int ACTION_BITS    = 3;
  localparam int STATUS_BITS    = 2;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd128;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_REQUEST         = 3'd0,
    ACT_RELEASE         = 3'd1,
    ACT_BIND            = 3'd2,
    ACT_FIND            = 3'd3,
    ACT_RESERVE_DEFAULT = 3'd4,
    ACT_RELEASE_DEFAULT = 3'd5
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  // Operation broadcast to every cell for the duration of one scan
  typedef struct packed {
    action_t                act;
    logic [ADDR_BITS-1:0]   addr;
    logic [LIMIT_BITS-1:0]  limit;
  } op_t;

  // Token walking the chain, one cell per cycle
  typedef struct packed {
    logic                   live;
    logic                   hit;
    logic [ADDR_BITS-1:0]   addr;
  } token_t;

endpackage

// ===== rtl/bus_address_allocator.sv =====
// Bus address allocator: a chain of ADDRESS_COUNT cells swept by a token.
// Request, release, bind and find: the accepted action is registered and a token then walks
// the chain one cell per cycle; the result is captured when it leaves the last cell.
// Default-address and spare actions skip the scan. New actions are accepted only in idle, and
// a result held in the output register stalls the block until it is taken.
// Synchronous reset clears all addresses, frees the default address, limit 128.
module bus_address_allocator #(
  parameter int ADDRESS_COUNT = baa_pkg::ADDRESS_COUNT_DEF,
  parameter int HANDLE_BITS   = baa_pkg::HANDLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [baa_pkg::LIMIT_BITS-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [baa_pkg::ACTION_BITS-1:0]     action,
  input  logic [baa_pkg::ADDR_BITS-1:0]       address,
  input  logic [baa_pkg::HANDLE_IN_BITS-1:0]  handle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [baa_pkg::STATUS_BITS-1:0]     status,
  output logic [baa_pkg::ADDR_BITS-1:0]       address_out
);
  import baa_pkg::*;

  state_t                 state;
  state_t                 state_next;
  op_t                    op;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   start;
  logic                   default_free;
  logic [LIMIT_BITS-1:0]  limit;
  status_t                res_status;
  logic [ADDR_BITS-1:0]   res_addr;
  status_t                imm_status;
  status_t                end_status;
  logic [ADDR_BITS-1:0]   end_addr;
  logic                   accept;
  logic                   load_out;
  logic                   scan_act;
  action_t                act_in;

  token_t tok [ADDRESS_COUNT+1];

  assign act_in = action_t'(action);
  assign accept = in_valid && in_ready;

  assign tok[0] = '{live: start, hit: 1'b0, addr: '0};

  for (genvar i = 0; i < ADDRESS_COUNT; i++) begin : g_cell
    baa_cell #(
      .INDEX       (i),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .op      (op),
      .handle  (handle_q),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    case (act_in) inside
      ACT_REQUEST, ACT_RELEASE, ACT_BIND, ACT_FIND: scan_act = 1'b1;
      default:                                      scan_act = 1'b0;
    endcase
  end

  always_comb begin
    imm_status = ST_OK;
    if (act_in == ACT_RESERVE_DEFAULT && !default_free) imm_status = ST_BUSY;
  end

  always_comb begin
    if (tok[ADDRESS_COUNT].hit) begin
      end_status = ST_OK;
      end_addr   = tok[ADDRESS_COUNT].addr;
    end else begin
      end_status = (op.act == ACT_REQUEST) ? ST_LIMIT : ST_NOT_FOUND;
      end_addr   = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = scan_act ? S_SCAN : S_HOLD;
      S_SCAN: if (tok[ADDRESS_COUNT].live) state_next = S_HOLD;
      S_HOLD: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: ;
      S_HOLD: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      start        <= 1'b0;
      default_free <= 1'b1;
      limit        <= LIMIT_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept && scan_act;
      if (cfg_wen) limit <= cfg_wdata;
      if (accept && act_in == ACT_RESERVE_DEFAULT) default_free <= 1'b0;
      if (accept && act_in == ACT_RELEASE_DEFAULT) default_free <= 1'b1;
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op.act   <= act_in;
      op.addr  <= address;
      op.limit <= limit;
      handle_q <= HANDLE_BITS'(handle);
      res_status <= imm_status;
      res_addr   <= '0;
    end else if (state == S_SCAN && tok[ADDRESS_COUNT].live) begin
      res_status <= end_status;
      res_addr   <= end_addr;
    end
    if (load_out) begin
      status      <= res_status;
      address_out <= res_addr;
    end
  end

endmodule

// ===== rtl/baa_cell.sv =====
// One allocator cell: holds the used flag and bound handle of one address
// and forwards the scan token to the next cell. Depends on baa_pkg.
module baa_cell #(
  parameter int INDEX       = 0,
  parameter int HANDLE_BITS = baa_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  baa_pkg::op_t           op,
  input  logic [HANDLE_BITS-1:0] handle,
  input  baa_pkg::token_t        tok_in,
  output baa_pkg::token_t        tok_out
);
  import baa_pkg::*;

  localparam bit ADDR_REACH  = INDEX < (1 << ADDR_BITS);
  localparam bit LIMIT_REACH = (INDEX >= 1) && (INDEX < (1 << LIMIT_BITS));
  localparam logic [ADDR_BITS-1:0]  IDX_ADDR  = ADDR_BITS'(INDEX);
  localparam logic [LIMIT_BITS-1:0] IDX_LIMIT = LIMIT_BITS'(INDEX);

  logic                   used;
  logic                   used_next;
  logic [HANDLE_BITS-1:0] bound;
  logic [HANDLE_BITS-1:0] bound_next;
  logic                   claim;
  logic                   addr_match;

  assign addr_match = ADDR_REACH && (op.addr == IDX_ADDR);

  always_comb begin
    claim      = 1'b0;
    used_next  = used;
    bound_next = bound;
    if (tok_in.live) begin
      unique case (op.act)
        ACT_REQUEST: begin
          claim = LIMIT_REACH && (IDX_LIMIT < op.limit) && !used && !tok_in.hit;
          if (claim) begin
            used_next  = 1'b1;
            bound_next = '1;
          end
        end
        ACT_RELEASE: begin
          claim = addr_match && used;
          if (claim) used_next = 1'b0;
        end
        ACT_BIND: begin
          claim = addr_match && used;
          if (claim) bound_next = handle;
        end
        ACT_FIND: begin
          claim = used && (bound == handle) && !tok_in.hit;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= 1'b0;
      tok_out.live <= 1'b0;
    end else begin
      used         <= used_next;
      tok_out.live <= tok_in.live;
    end
  end

  always_ff @(posedge clk) begin
    bound       <= bound_next;
    tok_out.hit <= tok_in.hit | claim;
    // keep the first hit's address as it travels down
    tok_out.addr <= claim ? IDX_ADDR : tok_in.addr;
  end

endmodule

// ===== rtl/baa_checker.sv =====
// Port-level checker for the bus address allocator, bound to the top level.
// Depends on baa_pkg and bus_address_allocator.
module baa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [baa_pkg::STATUS_BITS-1:0] status,
  input logic [baa_pkg::ADDR_BITS-1:0]   address_out
);
  import baa_pkg::*;

  // one transaction in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // a failing status never carries an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (address_out == '0))
    else $error("failing status with nonzero address");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(address_out)))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

endmodule

bind bus_address_allocator baa_checker u_baa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .address_out (address_out)
);

// ===== tb/sv/tb.sv =====
// Testbench for bus_address_allocator: a directed table, then random phases
// over several address limits and idling patterns, checked by an in-bench predictor.
// Depends on rtl/baa_pkg.sv and rtl/bus_address_allocator.sv.
`timescale 1ns / 100ps

module tb;
  import baa_pkg::*;

  localparam int ADDRESS_COUNT   = ADDRESS_COUNT_DEF;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int PHASES          = 8;
  localparam int CYCLE_LIMIT     = 1_200_000;
  localparam int REPORT_LIMIT    = 10;
  localparam int PLAN_ROWS       = 30;

  localparam logic [ACTION_BITS-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACTION_BITS-1:0] ACT_SPARE7 = 3'd7;
  localparam logic [HANDLE_IN_BITS-1:0] UNBOUND_HANDLE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [ACTION_BITS-1:0]    act;
    logic [ADDR_BITS-1:0]      adr;
    logic [HANDLE_IN_BITS-1:0] hdl;
  } bus_op_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] addr;
  } alloc_result_t;

  // Either a limit write (cfg set) or one transaction with an optional fixed answer
  typedef struct packed {
    logic                      cfg;
    logic [LIMIT_BITS-1:0]     lim;
    logic [ACTION_BITS-1:0]    act;
    logic [ADDR_BITS-1:0]      adr;
    logic [HANDLE_IN_BITS-1:0] hdl;
    logic                      typed;
    logic [STATUS_BITS-1:0]    st;
    logic [ADDR_BITS-1:0]      res;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wen = 1'b0;
  logic [LIMIT_BITS-1:0]     cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [ACTION_BITS-1:0]    action = '0;
  logic [ADDR_BITS-1:0]      address = '0;
  logic [HANDLE_IN_BITS-1:0] handle = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_BITS-1:0]    status;
  logic [ADDR_BITS-1:0]      address_out;

  // Predictor state
  bit                        used_addr [ADDRESS_COUNT];
  logic [HANDLE_IN_BITS-1:0] handle_of [ADDRESS_COUNT];
  bit                        dflt_free;
  logic [LIMIT_BITS-1:0]     limit_reg;

  alloc_result_t expected_q [$];
  int            mismatches = 0;
  int            send_pct = 0;
  int            stall_pct = 0;
  int unsigned   cycle_count = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{1'b0, 8'd0,   ACT_REQUEST,         7'd0,   32'd0,          1'b1, ST_OK,        7'd1},
    '{1'b0, 8'd0,   ACT_REQUEST,         7'd0,   32'd0,          1'b1, ST_OK,        7'd2},
    '{1'b0, 8'd0,   ACT_FIND,            7'd0,   UNBOUND_HANDLE, 1'b1, ST_OK,        7'd1},
    '{1'b0, 8'd0,   ACT_BIND,            7'd2,   32'd0,          1'b1, ST_OK,        7'd2},
    '{1'b0, 8'd0,   ACT_BIND,            7'd0,   32'd5,          1'b1, ST_NOT_FOUND, 7'd0},
    '{1'b0, 8'd0,   ACT_RELEASE,         7'd127, 32'd0,          1'b1, ST_NOT_FOUND, 7'd0},
    '{1'b0, 8'd0,   ACT_FIND,            7'd0,   32'd0,          1'b0, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_RELEASE,         7'd1,   32'd0,          1'b1, ST_OK,        7'd1},
    '{1'b0, 8'd0,   ACT_REQUEST,         7'd127, 32'd0,          1'b1, ST_OK,        7'd1},
    '{1'b0, 8'd0,   ACT_BIND,            7'd1,   32'hA5A5_5A5A,  1'b1, ST_OK,        7'd1},
    '{1'b0, 8'd0,   ACT_FIND,            7'd0,   32'hA5A5_5A5A,  1'b1, ST_OK,        7'd1},
    '{1'b0, 8'd0,   ACT_FIND,            7'd0,   32'h1234_5678,  1'b1, ST_NOT_FOUND, 7'd0},
    '{1'b0, 8'd0,   ACT_RESERVE_DEFAULT, 7'd0,   32'd0,          1'b1, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_RESERVE_DEFAULT, 7'd0,   32'd0,          1'b1, ST_BUSY,      7'd0},
    '{1'b0, 8'd0,   ACT_RELEASE_DEFAULT, 7'd0,   32'd0,          1'b1, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_RELEASE_DEFAULT, 7'd0,   32'd0,          1'b1, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_SPARE6,          7'd5,   32'd7,          1'b1, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_SPARE7,          7'd127, UNBOUND_HANDLE, 1'b1, ST_OK,        7'd0},
    '{1'b1, 8'd0,   ACT_REQUEST,         7'd0,   32'd0,          1'b0, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_REQUEST,         7'd0,   32'd0,          1'b1, ST_LIMIT,     7'd0},
    '{1'b1, 8'd1,   ACT_REQUEST,         7'd0,   32'd0,          1'b0, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_REQUEST,         7'd0,   32'd0,          1'b1, ST_LIMIT,     7'd0},
    '{1'b1, 8'd4,   ACT_REQUEST,         7'd0,   32'd0,          1'b0, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_REQUEST,         7'd0,   32'd0,          1'b1, ST_OK,        7'd3},
    '{1'b0, 8'd0,   ACT_REQUEST,         7'd0,   32'd0,          1'b1, ST_LIMIT,     7'd0},
    '{1'b1, 8'd2,   ACT_REQUEST,         7'd0,   32'd0,          1'b0, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_RELEASE,         7'd3,   32'd0,          1'b1, ST_OK,        7'd3},
    '{1'b0, 8'd0,   ACT_RELEASE,         7'd0,   32'd0,          1'b1, ST_NOT_FOUND, 7'd0},
    '{1'b1, 8'd255, ACT_REQUEST,         7'd0,   32'd0,          1'b0, ST_OK,        7'd0},
    '{1'b0, 8'd0,   ACT_REQUEST,         7'd0,   32'd0,          1'b0, ST_OK,        7'd0}
  };

  logic [LIMIT_BITS-1:0] phase_limit [PHASES] = '{8'd128, 8'd6, 8'd255, 8'd12,
                                                  8'd127, 8'd3, 8'd129, 8'd40};
  int phase_req_pct [PHASES] = '{70, 35, 45, 35, 55, 35, 60, 40};

  bus_address_allocator uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .address     (address),
    .handle      (handle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .address_out (address_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alloc_result_t predict_alloc(bus_op_t op);
    alloc_result_t r;
    int lim;
    int a;
    r.status = ST_OK;
    r.addr   = '0;
    case (op.act)
      ACT_REQUEST: begin
        lim = (limit_reg < ADDRESS_COUNT) ? limit_reg : ADDRESS_COUNT;
        r.status = ST_LIMIT;
        for (a = 1; a < lim; a++) begin
          if (!used_addr[a] && r.status == ST_LIMIT) begin
            used_addr[a] = 1'b1;
            handle_of[a] = UNBOUND_HANDLE;
            r.status = ST_OK;
            r.addr   = ADDR_BITS'(a);
          end
        end
      end
      ACT_RELEASE: begin
        if (used_addr[op.adr]) begin
          used_addr[op.adr] = 1'b0;
          r.addr = op.adr;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      ACT_BIND: begin
        if (used_addr[op.adr]) begin
          handle_of[op.adr] = op.hdl;
          r.addr = op.adr;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      ACT_FIND: begin
        r.status = ST_NOT_FOUND;
        for (a = 0; a < ADDRESS_COUNT; a++) begin
          if (used_addr[a] && handle_of[a] == op.hdl && r.status == ST_NOT_FOUND) begin
            r.status = ST_OK;
            r.addr   = ADDR_BITS'(a);
          end
        end
      end
      ACT_RESERVE_DEFAULT: begin
        if (dflt_free) dflt_free = 1'b0;
        else r.status = ST_BUSY;
      end
      ACT_RELEASE_DEFAULT: dflt_free = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_used_address();
    int start;
    int idx;
    int k;
    start = $urandom_range(0, ADDRESS_COUNT - 1);
    for (k = 0; k < ADDRESS_COUNT; k++) begin
      idx = (start + k) % ADDRESS_COUNT;
      if (used_addr[idx]) return idx;
    end
    return -1;
  endfunction

  // Mix wide random handles with a small pool so finds and binds collide
  function automatic logic [HANDLE_IN_BITS-1:0] pick_handle();
    logic [HANDLE_IN_BITS-1:0] h;
    case ($urandom_range(0, 3))
      0: h = $urandom;
      1: h = $urandom_range(0, 7);
      2: h = UNBOUND_HANDLE;
      default: h = ~$urandom_range(0, 7);
    endcase
    return h;
  endfunction

  // Requests with chance req_pct; other actions mostly aimed at used addresses and known handles, some noise
  function automatic bus_op_t make_op(int req_pct);
    bus_op_t op;
    int roll;
    int pick;
    op.act = ACT_REQUEST;
    op.adr = ADDR_BITS'($urandom_range(0, ADDRESS_COUNT - 1));
    op.hdl = pick_handle();
    if ($urandom_range(0, 99) >= req_pct) begin
      roll = $urandom_range(0, 99);
      pick = pick_used_address();
      if (roll < 30) begin
        op.act = ACT_RELEASE;
        if (pick >= 0 && $urandom_range(0, 4) != 0) op.adr = ADDR_BITS'(pick);
      end else if (roll < 60) begin
        op.act = ACT_BIND;
        if (pick >= 0 && $urandom_range(0, 4) != 0) op.adr = ADDR_BITS'(pick);
      end else if (roll < 85) begin
        op.act = ACT_FIND;
        if (pick >= 0 && $urandom_range(0, 3) != 0) op.hdl = handle_of[pick];
      end else if (roll < 92) begin
        op.act = ACT_RESERVE_DEFAULT;
      end else if (roll < 98) begin
        op.act = ACT_RELEASE_DEFAULT;
      end else begin
        op.act = $urandom_range(0, 1) ? ACT_SPARE7 : ACT_SPARE6;
      end
    end
    return op;
  endfunction

  task automatic send_op(bus_op_t op, bit typed, alloc_result_t fixed);
    alloc_result_t pred;
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid <= 1'b1;
    action   <= op.act;
    address  <= op.adr;
    handle   <= op.hdl;
    do @(posedge clk); while (!in_ready);
    pred = predict_alloc(op);
    expected_q.push_back(typed ? fixed : pred);
  endtask

  // Drop valid and wait for every pending result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_limit(logic [LIMIT_BITS-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    limit_reg = value;
  endtask

  task automatic note_failure(string msg);
    if (mismatches < REPORT_LIMIT) $display("%s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d address %0d",
                               status, address_out));
      end else begin
        want = expected_q.pop_front();
        if (want.status != status || want.addr != address_out)
          note_failure($sformatf("mismatch: status exp %0d got %0d, address exp %0d got %0d",
                                 want.status, status, want.addr, address_out));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    int p;
    bus_op_t op;
    alloc_result_t fixed;
    foreach (used_addr[i]) used_addr[i] = 1'b0;
    dflt_free = 1'b1;
    limit_reg = LIMIT_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].cfg) begin
        drain_results();
        write_limit(plan[i].lim);
      end else begin
        op.act = plan[i].act;
        op.adr = plan[i].adr;
        op.hdl = plan[i].hdl;
        fixed.status = status_t'(plan[i].st);
        fixed.addr   = plan[i].res;
        send_op(op, plan[i].typed, fixed);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_limit(p == PHASES - 1 ? LIMIT_BITS'($urandom_range(0, 255)) : phase_limit[p]);
      case (p % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 56; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 56; end
        default: begin send_pct = 9; stall_pct = 9; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        op = make_op(phase_req_pct[p]);
        send_op(op, 1'b0, fixed);
      end
    end

    drain_results();
    repeat (ADDRESS_COUNT + 8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
